// File: hw/rtl/tcre_pkg.sv
// shared types and constants for the typed compare run extractor
package tcre_pkg;

   localparam logic [3:0] VT_S8  = 4'd0;
   localparam logic [3:0] VT_S16 = 4'd1;
   localparam logic [3:0] VT_S32 = 4'd2;
   localparam logic [3:0] VT_S64 = 4'd3;
   localparam logic [3:0] VT_U8  = 4'd4;
   localparam logic [3:0] VT_U16 = 4'd5;
   localparam logic [3:0] VT_U32 = 4'd6;
   localparam logic [3:0] VT_U64 = 4'd7;
   localparam logic [3:0] VT_F32 = 4'd8;
   localparam logic [3:0] VT_F64 = 4'd9;

   localparam logic [2:0] OP_EQ = 3'd0;
   localparam logic [2:0] OP_NE = 3'd1;
   localparam logic [2:0] OP_GT = 3'd2;
   localparam logic [2:0] OP_LT = 3'd3;
   localparam logic [2:0] OP_GE = 3'd4;
   localparam logic [2:0] OP_LE = 3'd5;

   localparam logic [1:0] REG_VALUE_TYPE    = 2'd0;
   localparam logic [1:0] REG_COMPARE_OP    = 2'd1;
   localparam logic [1:0] REG_USE_CONSTANT  = 2'd2;
   localparam logic [1:0] REG_COMPARE_VALUE = 2'd3;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic       hit;
      logic       last;
      logic [3:0] size;
   } class_type;

   // element size in bytes
   function automatic logic [3:0] elem_bytes(input logic [3:0] t);
      logic [3:0] r;
      r = 4'd8;
      case (t)
         VT_S8, VT_U8:            r = 4'd1;
         VT_S16, VT_U16:          r = 4'd2;
         VT_S32, VT_U32, VT_F32:  r = 4'd4;
         default:                 r = 4'd8;
      endcase
      return r;
   endfunction

endpackage

// File: hw/rtl/typed_compare_run_extractor_core.sv
// Typed compare run extractor. One item is taken per clock while full is low: the front
// stage registers the typed compare, the back stage updates the open run and may write one
// range into a two-entry result queue. A range reaches the result ports through the front
// stage register and the queue. full rises while the queue holds two ranges, or holds one
// that is not being popped while another may still be on its way, so an item can be taken
// every cycle as long as results are popped.
module typed_compare_run_extractor_core
   import tcre_pkg::*;
#(
   parameter int ADDR_BITS = 23
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [63:0]          csr_data,
   input  logic                 push,
   output logic                 full,
   input  logic [ADDR_BITS-1:0] req_element_address,
   input  logic [63:0]          req_current_value,
   input  logic [63:0]          req_snapshot_value,
   input  logic                 req_last_in_region,
   output logic                 empty,
   input  logic                 pop,
   output logic [ADDR_BITS-1:0] rsp_range_start,
   output logic [ADDR_BITS:0]   rsp_range_bytes
);

   logic [3:0]  value_type_ff;
   logic [2:0]  compare_op_ff;
   logic        use_constant_ff;
   logic [63:0] compare_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_type_ff    <= VT_S8;
         compare_op_ff    <= OP_EQ;
         use_constant_ff  <= 1'b1;
         compare_value_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_VALUE_TYPE:    value_type_ff    <= csr_data[3:0];
            REG_COMPARE_OP:    compare_op_ff    <= csr_data[2:0];
            REG_USE_CONSTANT:  use_constant_ff  <= csr_data[0];
            REG_COMPARE_VALUE: compare_value_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic                 accept, f_valid, b_valid;
   class_type            f_class;
   logic [ADDR_BITS-1:0] f_addr, b_start;
   logic [ADDR_BITS:0]   b_bytes;
   logic [1:0]           q_count;

   // at most one item in flight in the front stage can still add a range
   assign full   = (q_count == 2'd2) || (q_count == 2'd1 && f_valid && !pop);
   assign accept = push && !full;

   tcre_front #(.ADDR_BITS(ADDR_BITS)) u_front (
      .clock(clock), .reset(reset),
      .value_type(value_type_ff), .compare_op(compare_op_ff),
      .use_constant(use_constant_ff), .compare_value(compare_value_ff),
      .in_valid(accept), .in_addr(req_element_address), .in_cur(req_current_value),
      .in_snap(req_snapshot_value), .in_last(req_last_in_region),
      .out_valid(f_valid), .out_class(f_class), .out_addr(f_addr)
   );

   tcre_back #(.ADDR_BITS(ADDR_BITS)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_class(f_class), .in_addr(f_addr),
      .out_valid(b_valid), .out_start(b_start), .out_bytes(b_bytes)
   );

   tcre_queue #(.WIDTH(2 * ADDR_BITS + 1)) u_queue (
      .clock(clock), .reset(reset),
      .push(b_valid), .push_data({b_start, b_bytes}),
      .pop(pop), .empty(empty),
      .pop_data({rsp_range_start, rsp_range_bytes}), .count(q_count)
   );

endmodule

// File: hw/rtl/tcre_front.sv
// front end: compares each item and classifies it as hit or miss
module tcre_front
   import tcre_pkg::*;
#(
   parameter int ADDR_BITS = 23
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [3:0]           value_type,
   input  logic [2:0]           compare_op,
   input  logic                 use_constant,
   input  logic [63:0]          compare_value,
   input  logic                 in_valid,
   input  logic [ADDR_BITS-1:0] in_addr,
   input  logic [63:0]          in_cur,
   input  logic [63:0]          in_snap,
   input  logic                 in_last,
   output logic                 out_valid,
   output class_type            out_class,
   output logic [ADDR_BITS-1:0] out_addr
);

   logic [63:0] rhs, ka, kb;
   logic        lt, gt, eq, nan_a, nan_b, hit;
   logic [3:0]  size;
   logic        sa, sb;

   function automatic logic [63:0] int_key(input logic [63:0] v, input logic [3:0] t);
      logic [63:0] r;
      r = v;
      case (t)
         VT_S8:  r = {{56{v[7]}}, v[7:0]} ^ {1'b1, 63'd0};
         VT_S16: r = {{48{v[15]}}, v[15:0]} ^ {1'b1, 63'd0};
         VT_S32: r = {{32{v[31]}}, v[31:0]} ^ {1'b1, 63'd0};
         VT_S64: r = v ^ {1'b1, 63'd0};
         VT_U8:  r = {56'd0, v[7:0]};
         VT_U16: r = {48'd0, v[15:0]};
         VT_U32: r = {32'd0, v[31:0]};
         default: r = v;
      endcase
      return r;
   endfunction

   // sign-magnitude to ordered key; zeros are collapsed by the caller
   function automatic logic [63:0] flt_key(input logic [63:0] v);
      logic [63:0] r;
      if (v[63]) r = ~v;
      else r = v | {1'b1, 63'd0};
      return r;
   endfunction

   always_comb begin
      rhs = use_constant ? compare_value : in_snap;
      size = elem_bytes(value_type);
      nan_a = 1'b0;
      nan_b = 1'b0;
      sa = 1'b0;
      sb = 1'b0;
      if (value_type == VT_F32) begin
         nan_a = (&in_cur[30:23]) && (|in_cur[22:0]);
         nan_b = (&rhs[30:23]) && (|rhs[22:0]);
         ka = flt_key({in_cur[31:0], 32'd0});
         kb = flt_key({rhs[31:0], 32'd0});
         sa = (in_cur[30:0] == 31'd0);
         sb = (rhs[30:0] == 31'd0);
      end else if (value_type == VT_F64) begin
         nan_a = (&in_cur[62:52]) && (|in_cur[51:0]);
         nan_b = (&rhs[62:52]) && (|rhs[51:0]);
         ka = flt_key(in_cur);
         kb = flt_key(rhs);
         sa = (in_cur[62:0] == 63'd0);
         sb = (rhs[62:0] == 63'd0);
      end else begin
         ka = int_key(in_cur, value_type);
         kb = int_key(rhs, value_type);
      end
      if (sa) ka = {1'b1, 63'd0};
      if (sb) kb = {1'b1, 63'd0};
      eq = (ka == kb) && !nan_a && !nan_b;
      lt = (ka < kb) && !nan_a && !nan_b;
      gt = (ka > kb) && !nan_a && !nan_b;
      case (compare_op)
         OP_EQ:   hit = eq;
         OP_NE:   hit = !eq;
         OP_GT:   hit = gt;
         OP_LT:   hit = lt;
         OP_GE:   hit = gt || eq;
         OP_LE:   hit = lt || eq;
         default: hit = 1'b0;
      endcase
   end

   logic                 valid_ff;
   class_type            class_ff;
   logic [ADDR_BITS-1:0] addr_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= in_valid;
      class_ff <= '{hit: hit, last: in_last, size: size};
      addr_ff  <= in_addr;
   end

   assign out_valid = valid_ff;
   assign out_class = class_ff;
   assign out_addr  = addr_ff;

endmodule

// File: hw/rtl/tcre_back.sv
// back end: tracks the open run and forms ranges
module tcre_back
   import tcre_pkg::*;
#(
   parameter int ADDR_BITS = 23
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  class_type            in_class,
   input  logic [ADDR_BITS-1:0] in_addr,
   output logic                 out_valid,
   output logic [ADDR_BITS-1:0] out_start,
   output logic [ADDR_BITS:0]   out_bytes
);

   logic                 open_ff, open_in;
   logic [ADDR_BITS-1:0] begin_ff, begin_in, start;
   logic [ADDR_BITS:0]   end_addr;

   always_comb begin
      open_in   = open_ff;
      begin_in  = begin_ff;
      out_valid = 1'b0;
      start     = open_ff ? begin_ff : in_addr;
      end_addr  = {1'b0, in_addr};
      if (in_valid) begin
         if (in_class.hit) begin
            if (!open_ff) begin
               begin_in = in_addr;
            end
            open_in = !in_class.last;
            if (in_class.last) begin
               out_valid = 1'b1;
               end_addr = {1'b0, in_addr} + {{(ADDR_BITS - 3){1'b0}}, in_class.size};
            end
         end else begin
            out_valid = open_ff;
            open_in   = 1'b0;
         end
      end
      out_start = in_class.hit ? start : begin_ff;
      out_bytes = end_addr - {1'b0, out_start};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= 1'b0;
         begin_ff <= '0;
      end else begin
         open_ff  <= open_in;
         begin_ff <= begin_in;
      end
   end

endmodule

// File: hw/rtl/tcre_queue.sv
// small result queue between back end and result ports
module tcre_queue
   import tcre_pkg::*;
#(
   parameter int WIDTH = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data,
   output logic [1:0]       count
);

   logic [WIDTH-1:0] mem [QUEUE_DEPTH];
   logic             wr_ff, rd_ff;
   logic [1:0]       count_ff;
   logic             do_pop;

   assign empty  = (count_ff == 2'd0);
   assign do_pop = pop && !empty;
   assign pop_data = mem[rd_ff];
   assign count = count_ff;

   always_ff @(posedge clock) begin
      if (push) mem[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (do_pop) rd_ff <= !rd_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, do_pop};
      end
   end

endmodule
